[hw/rtl/aes_pkg.sv]
// shared types, tables and round functions for the aes-128 pipeline
package aes_pkg;

  localparam int unsigned BlockBits = 128;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned KeyBytes  = 16;
  localparam int unsigned HalfBits  = 64;
  localparam int unsigned CfgIdxBits = 1;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  typedef logic [BlockBits-1:0] block_t;

  // pipeline stage control
  typedef struct packed {
    logic valid;
    logic stall;
  } stage_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of a block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(block_t b, int unsigned i);
    return b[BlockBits-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // subbytes then shiftrows
  function automatic block_t sub_shift(block_t s);
    block_t t;
    t = '0;
    for (int unsigned row = 0; row < 4; row++) begin
      for (int unsigned col = 0; col < 4; col++) begin
        t[BlockBits-1-8*(4*col+row) -: 8] = SBOX[get_byte(s, 4*((col+row)%4)+row)];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[BlockBits-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[BlockBits-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[BlockBits-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[BlockBits-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // round key r from round key r-1, r counted from 1
  function automatic block_t next_key(block_t k, logic [7:0] rc);
    block_t n;
    logic [31:0] t, w;
    t = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
         SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
    w = k[127:96] ^ t;
    n[127:96] = w;
    w = k[95:64] ^ w;
    n[95:64] = w;
    w = k[63:32] ^ w;
    n[63:32] = w;
    n[31:0] = k[31:0] ^ w;
    return n;
  endfunction

endpackage

[hw/rtl/aes_if.sv]
// valid/ready channel carrying a two-half 128-bit item
interface aes_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  modport source (output valid, output data_high, output data_low, input ready);
  modport sink (input valid, input data_high, input data_low, output ready);
endinterface

// configuration write channel
interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[hw/rtl/aes_round.sv]
// one registered aes round with its key expansion step
module aes_round #(
  parameter bit LastRound = 1'b0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic                  valid_i,
  input  aes_pkg::block_t       state_i,
  input  aes_pkg::block_t       key_i,
  input  logic [7:0]            rcon_i,
  output logic                  valid_o,
  output aes_pkg::block_t       state_o,
  output aes_pkg::block_t       key_o
);
  import aes_pkg::*;

  block_t key_d, state_d, sub_d;
  logic   valid_q;
  block_t state_q, key_q;

  // round datapath
  always_comb begin
    key_d = next_key(key_i, rcon_i);
    sub_d = sub_shift(state_i);
    state_d = (LastRound ? sub_d : mix_columns(sub_d)) ^ key_d;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;
endmodule

[hw/rtl/aes128_block_encrypt.sv]
// aes-128 encryption top level: key registers, whitening and ten round stages
//
// usage
//   cfg_if writes the key: index 0 is key bytes 0..7, index 1 is bytes 8..15.
//   cfg_if is always ready; write only while no item is in flight.
//   in_if carries plaintext halves, out_if returns ciphertext halves,
//   byte 0 in the top bits of the high half.
// stages and throughput
//   an item passes one stage for the initial key addition, then one stage
//   per round, ten rounds; the whole round, key step included, is one stage.
//   one item per cycle while the receiver is not stalling.
// stalls
//   the pipeline moves when the output stage is empty or being taken;
//   a stalled receiver holds every stage, nothing is lost or repeated.
// reset
//   rst_ni clears all valid bits and sets the key to all zeros.
module aes128_block_encrypt (
  input  logic  clk_i,
  input  logic  rst_ni,
  aes_cfg_if.sink cfg_if,
  aes_if.sink     in_if,
  aes_if.source   out_if
);
  import aes_pkg::*;

  logic [HalfBits-1:0] key_high_q, key_low_q;
  logic   advance;
  logic   v0_q;
  block_t s0_q, k0_q;
  logic   vld [NumRounds+1];
  block_t st  [NumRounds+1];
  block_t ky  [NumRounds+1];

  assign cfg_if.ready = 1'b1;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_reg_e'(cfg_if.index))
        REG_KEY_HIGH: key_high_q <= cfg_if.wdata;
        REG_KEY_LOW:  key_low_q  <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

  assign advance     = !vld[NumRounds] || out_if.ready;
  assign in_if.ready = advance;

  // initial key addition stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (advance) begin
      v0_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s0_q <= {in_if.data_high, in_if.data_low} ^ {key_high_q, key_low_q};
      k0_q <= {key_high_q, key_low_q};
    end
  end

  assign vld[0] = v0_q;
  assign st[0]  = s0_q;
  assign ky[0]  = k0_q;

  // round stages
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    aes_round #(.LastRound(r == NumRounds-1)) u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .valid_i   (vld[r]),
      .state_i   (st[r]),
      .key_i     (ky[r]),
      .rcon_i    (RCON[r]),
      .valid_o   (vld[r+1]),
      .state_o   (st[r+1]),
      .key_o     (ky[r+1])
    );
  end

  assign out_if.valid     = vld[NumRounds];
  assign out_if.data_high = st[NumRounds][BlockBits-1:HalfBits];
  assign out_if.data_low  = st[NumRounds][HalfBits-1:0];

`ifndef SYNTHESIS
  // a waiting result must hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data_high))
    else $error("result dropped under stall");
  // input ready follows the output stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("pipeline blocked while output empty");
  // accepted item reaches the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> v0_q)
    else $error("item lost at entry");
`endif
endmodule

[dv/aes128_block_encrypt_checker.sv]
// checker for the aes-128 pipeline: watches the channels, predicts ciphertexts and compares
module aes128_block_encrypt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  aes_cfg_if.sink     cfg_mon,
  aes_if.sink         in_mon,
  aes_if.sink         out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned seen_o
);
  import aes_pkg::*;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } half_pair_t;

  logic [7:0] sub_lut [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic [63:0] key_high_q, key_low_q;
  half_pair_t  cipher_queue [$];

  function automatic logic [7:0] dbl(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // full aes-128 encryption on byte arrays, byte 0 from the top of the high half
  function automatic half_pair_t encrypt_block(logic [63:0] ph, logic [63:0] pl,
                                               logic [63:0] kh, logic [63:0] kl);
    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] tmp [16];
    logic [7:0] w [4];
    logic [7:0] a0, a1, a2, a3, all, rc;
    half_pair_t res;
    for (int i = 0; i < 8; i++) begin
      st[i] = ph[63-8*i -: 8];
      st[8+i] = pl[63-8*i -: 8];
      rk[i] = kh[63-8*i -: 8];
      rk[8+i] = kl[63-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    rc = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      // substitute and shift rows
      for (int row = 0; row < 4; row++)
        for (int col = 0; col < 4; col++)
          tmp[4*col+row] = sub_lut[st[4*((col+row)%4)+row]];
      st = tmp;
      // mix columns except in the last round
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
          st[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
          st[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
          st[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
        end
      end
      // key schedule step
      for (int i = 0; i < 4; i++) w[i] = sub_lut[rk[12+((i+1)%4)]];
      w[0] ^= rc;
      for (int i = 0; i < 4; i++) rk[i] ^= w[i];
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rc = dbl(rc);
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 8; i++) begin
      res.high[63-8*i -: 8] = st[i];
      res.low[63-8*i -: 8] = st[8+i];
    end
    return res;
  endfunction

  assign pending_o = cipher_queue.size();

  // watch key writes, plaintexts and ciphertexts
  always @(posedge clk_i or negedge rst_ni) begin
    half_pair_t exp_c;
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q <= '0;
      fail_count_o <= 0;
      seen_o <= 0;
      cipher_queue.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_e'(cfg_mon.index))
          REG_KEY_HIGH: key_high_q <= cfg_mon.wdata;
          REG_KEY_LOW:  key_low_q <= cfg_mon.wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        cipher_queue.push_back(encrypt_block(in_mon.data_high, in_mon.data_low,
                                             key_high_q, key_low_q));
      if (out_mon.valid && out_mon.ready) begin
        seen_o <= seen_o + 1;
        if (cipher_queue.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected ciphertext %h_%h", out_mon.data_high, out_mon.data_low);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_c = cipher_queue.pop_front();
          if (exp_c.high !== out_mon.data_high || exp_c.low !== out_mon.data_low) begin
            if (fail_count_o < 10)
              $display("ciphertext mismatch: expected %h_%h got %h_%h",
                       exp_c.high, exp_c.low, out_mon.data_high, out_mon.data_low);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[dv/aes128_block_encrypt_tb.sv]
// testbench top: drives keys and plaintext items into the aes-128 pipeline and gives the verdict
module aes128_block_encrypt_tb;
  import aes_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_count, pending, seen, cycles;
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned sent;

  aes_cfg_if cfg_ch();
  aes_if     in_ch();
  aes_if     out_ch();

  aes128_block_encrypt i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_ch.sink),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  aes128_block_encrypt_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_ch.sink),
    .in_mon       (in_ch.sink),
    .out_mon      (out_ch.sink),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .seen_o       (seen)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // cycle limit guards against a hang
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_key(logic [63:0] hi, logic [63:0] lo);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_KEY_HIGH;
    cfg_ch.wdata <= hi;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.index <= REG_KEY_LOW;
    cfg_ch.wdata <= lo;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // offer one plaintext item, with random idle cycles ahead of it
  task automatic send_plain(logic [63:0] hi, logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_high <= hi;
    in_ch.data_low <= lo;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] kh, kl;
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_KEY_HIGH;
    cfg_ch.wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_high = '0;
    in_ch.data_low = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: key never written, then the fips-197 vectors and extreme keys
    send_plain('0, '0);
    send_plain('1, '1);
    drain();
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_plain('0, '0);
    send_plain('1, '1);
    send_plain(64'h8000000000000000, 64'h0000000000000001);
    drain();
    write_key('1, '1);
    send_plain('0, '0);
    send_plain('1, '1);
    send_plain(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_plain(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    drain();

    // random phases with different idle and stall patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      kh = rand64();
      kl = rand64();
      if (ph == 3) kh = '0;
      if (ph == 6) kl = '1;
      write_key(kh, kl);
      for (int n = 0; n < 105; n++) send_plain(rand64(), rand64());
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    $display("encrypted %0d blocks under 12 keys, %0d ciphertexts compared", sent, seen);
    $display("pipeline exercised with idle sender and stalled receiver phases");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
